// ===== rtl/cfd_pkg.sv =====
// Package for the command frame deframer: configuration register indexes,
// parse phase, command kind and verdict codes, and the shared structs.
// No dependencies.
package cfd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegSyncFirst     = 3'd0,
    RegSyncSecond    = 3'd1,
    RegTextCommand   = 3'd2,
    RegBinaryCommand = 3'd3,
    RegSdfsCommand   = 3'd4,
    RegMaxPayload    = 3'd5,
    RegSdfsMaxLength = 3'd6
  } cfd_reg_e;

  localparam logic [7:0]  SyncFirstRst     = 8'hBE;
  localparam logic [7:0]  SyncSecondRst    = 8'hBA;
  localparam logic [7:0]  TextCommandRst   = 8'h5D;
  localparam logic [7:0]  BinaryCommandRst = 8'h5E;
  localparam logic [7:0]  SdfsCommandRst   = 8'h5F;
  localparam logic [15:0] MaxPayloadRst    = 16'd512;
  localparam logic [15:0] SdfsMaxLengthRst = 16'd512;

  typedef enum logic [7:0] {
    PhSync0   = 8'b0000_0001,
    PhSync1   = 8'b0000_0010,
    PhLen0    = 8'b0000_0100,
    PhLen1    = 8'b0000_1000,
    PhCmd     = 8'b0001_0000,
    PhPayload = 8'b0010_0000,
    PhCk0     = 8'b0100_0000,
    PhCk1     = 8'b1000_0000
  } cfd_phase_e;

  typedef enum logic [1:0] {
    KindText     = 2'd0,
    KindBinary   = 2'd1,
    KindSdfs     = 2'd2,
    KindUnrouted = 2'd3
  } cfd_kind_e;

  typedef enum logic [2:0] {
    VerdictAccept   = 3'd0,
    VerdictChecksum = 3'd1,
    VerdictOverlong = 3'd2,
    VerdictUnrouted = 3'd3,
    VerdictSdfsLen  = 3'd4
  } cfd_verdict_e;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  text_command;
    logic [7:0]  binary_command;
    logic [7:0]  sdfs_command;
    logic [15:0] max_payload;
    logic [15:0] sdfs_max_length;
  } cfd_cfg_t;

  typedef struct packed {
    logic         payload_valid;
    logic [7:0]   payload_byte;
    logic [1:0]   lane;
    logic         frame_end;
    cfd_verdict_e verdict;
    logic [15:0]  frame_length;
  } cfd_result_t;

endpackage

// ===== rtl/cfd_if.sv =====
// Valid/ready channel interfaces of the command frame deframer: received
// byte beats in, result beats out. No dependencies.
interface cfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_data;

  modport source (output valid, output rx_data, input ready);
  modport sink   (input valid, input rx_data, output ready);
endinterface

interface cfd_res_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [1:0]  lane;
  logic        frame_end;
  logic [2:0]  verdict;
  logic [15:0] frame_length;

  modport source (output valid, output payload_valid, output payload_byte, output lane,
                  output frame_end, output verdict, output frame_length, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte, input lane,
                  input frame_end, input verdict, input frame_length, output ready);
endinterface

// ===== rtl/cfd_cfg_regs.sv =====
// Configuration register file of the command frame deframer.
// Depends on cfd_pkg.
module cfd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cfd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cfd_pkg::CfgDataW-1:0] cfg_wdata_i,
  output cfd_pkg::cfd_cfg_t            cfg_o
);

  cfd_pkg::cfd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first      <= cfd_pkg::SyncFirstRst;
      cfg_q.sync_second     <= cfd_pkg::SyncSecondRst;
      cfg_q.text_command    <= cfd_pkg::TextCommandRst;
      cfg_q.binary_command  <= cfd_pkg::BinaryCommandRst;
      cfg_q.sdfs_command    <= cfd_pkg::SdfsCommandRst;
      cfg_q.max_payload     <= cfd_pkg::MaxPayloadRst;
      cfg_q.sdfs_max_length <= cfd_pkg::SdfsMaxLengthRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cfd_pkg::RegSyncFirst:     cfg_q.sync_first      <= cfg_wdata_i[7:0];
        cfd_pkg::RegSyncSecond:    cfg_q.sync_second     <= cfg_wdata_i[7:0];
        cfd_pkg::RegTextCommand:   cfg_q.text_command    <= cfg_wdata_i[7:0];
        cfd_pkg::RegBinaryCommand: cfg_q.binary_command  <= cfg_wdata_i[7:0];
        cfd_pkg::RegSdfsCommand:   cfg_q.sdfs_command    <= cfg_wdata_i[7:0];
        cfd_pkg::RegMaxPayload:    cfg_q.max_payload     <= cfg_wdata_i;
        cfd_pkg::RegSdfsMaxLength: cfg_q.sdfs_max_length <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/cfd_parser.sv =====
// Frame parser of the command frame deframer: parse state registers and the
// per-byte next-state and result logic. Depends on cfd_pkg.
module cfd_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            rx_data_i,
  input  cfd_pkg::cfd_cfg_t     cfg_i,
  output cfd_pkg::cfd_result_t  res_o
);

  cfd_pkg::cfd_phase_e phase_q, phase_d;
  cfd_pkg::cfd_kind_e  kind_q, kind_d;
  logic [15:0] len_q, len_d;
  logic [15:0] seen_q, seen_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  ck_lo_q, ck_lo_d;
  logic        too_long_q, too_long_d;

  logic [15:0] sum_add;
  logic [15:0] seen_inc;
  logic [15:0] ck_word;

  assign sum_add  = sum_q + {8'd0, rx_data_i};
  assign seen_inc = seen_q + 16'd1;
  assign ck_word  = {rx_data_i, ck_lo_q};

  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    len_d      = len_q;
    seen_d     = seen_q;
    sum_d      = sum_q;
    ck_lo_d    = ck_lo_q;
    too_long_d = too_long_q;
    res_o      = '0;

    case (phase_q)
      cfd_pkg::PhSync0: begin
        if (rx_data_i == cfg_i.sync_first) begin
          sum_d   = {8'd0, rx_data_i};
          phase_d = cfd_pkg::PhSync1;
        end
      end
      cfd_pkg::PhSync1: begin
        if (rx_data_i == cfg_i.sync_second) begin
          sum_d   = sum_add;
          phase_d = cfd_pkg::PhLen0;
        end else if (rx_data_i == cfg_i.sync_first) begin
          sum_d = {8'd0, rx_data_i};
        end else begin
          phase_d = cfd_pkg::PhSync0;
        end
      end
      cfd_pkg::PhLen0: begin
        sum_d   = sum_add;
        len_d   = {8'd0, rx_data_i};
        phase_d = cfd_pkg::PhLen1;
      end
      cfd_pkg::PhLen1: begin
        sum_d      = sum_add;
        len_d      = {rx_data_i, len_q[7:0]};
        seen_d     = '0;
        too_long_d = len_d > cfg_i.max_payload;
        phase_d    = cfd_pkg::PhCmd;
      end
      cfd_pkg::PhCmd: begin
        sum_d = sum_add;
        if (rx_data_i == cfg_i.text_command) begin
          kind_d = cfd_pkg::KindText;
        end else if (rx_data_i == cfg_i.binary_command) begin
          kind_d = cfd_pkg::KindBinary;
        end else if (rx_data_i == cfg_i.sdfs_command) begin
          kind_d = cfd_pkg::KindSdfs;
        end else begin
          kind_d = cfd_pkg::KindUnrouted;
        end
        phase_d = (len_q != '0) ? cfd_pkg::PhPayload : cfd_pkg::PhCk0;
      end
      cfd_pkg::PhPayload: begin
        sum_d = sum_add;
        if (kind_q != cfd_pkg::KindUnrouted && !too_long_q) begin
          res_o.payload_valid = 1'b1;
          res_o.payload_byte  = rx_data_i;
        end
        seen_d = seen_inc;
        if (seen_inc >= len_q) begin
          phase_d = cfd_pkg::PhCk0;
        end
      end
      cfd_pkg::PhCk0: begin
        ck_lo_d = rx_data_i;
        phase_d = cfd_pkg::PhCk1;
      end
      cfd_pkg::PhCk1: begin
        res_o.frame_end = 1'b1;
        if (ck_word != sum_q) begin
          res_o.verdict = cfd_pkg::VerdictChecksum;
        end else if (too_long_q) begin
          res_o.verdict = cfd_pkg::VerdictOverlong;
        end else if (kind_q == cfd_pkg::KindUnrouted) begin
          res_o.verdict = cfd_pkg::VerdictUnrouted;
        end else if (kind_q == cfd_pkg::KindSdfs &&
                     (len_q == '0 || len_q > cfg_i.sdfs_max_length)) begin
          res_o.verdict = cfd_pkg::VerdictSdfsLen;
        end else begin
          res_o.verdict = cfd_pkg::VerdictAccept;
        end
        phase_d = cfd_pkg::PhSync0;
      end
      default: begin
        phase_d = cfd_pkg::PhSync0;
      end
    endcase

    if ((phase_q == cfd_pkg::PhCmd || phase_q == cfd_pkg::PhPayload ||
         phase_q == cfd_pkg::PhCk0 || phase_q == cfd_pkg::PhCk1) &&
        kind_d != cfd_pkg::KindUnrouted) begin
      res_o.lane = kind_d;
    end
    if (phase_q == cfd_pkg::PhLen1 || phase_q == cfd_pkg::PhCmd ||
        phase_q == cfd_pkg::PhPayload || phase_q == cfd_pkg::PhCk0 ||
        phase_q == cfd_pkg::PhCk1) begin
      res_o.frame_length = len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= cfd_pkg::PhSync0;
      kind_q     <= cfd_pkg::KindText;
      len_q      <= '0;
      seen_q     <= '0;
      sum_q      <= '0;
      ck_lo_q    <= '0;
      too_long_q <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      kind_q     <= kind_d;
      len_q      <= len_d;
      seen_q     <= seen_d;
      sum_q      <= sum_d;
      ck_lo_q    <= ck_lo_d;
      too_long_q <= too_long_d;
    end
  end

endmodule

// ===== rtl/command_frame_deframer_unit.sv =====
// Top level of the command frame deframer: config registers, parser and
// result register. Depends on cfd_pkg, cfd_if, cfd_cfg_regs, cfd_parser.
//
// Takes one received byte per beat and gives exactly one result beat per byte,
// registered, in the cycle after the byte is taken. A byte can be taken every
// cycle; rx_i.ready drops only while the result register holds a beat that
// res_o is not taking. The parse state updates once per byte in the parser's
// combinational next-state logic, so throughput is one byte per clock while res_o takes beats.
module command_frame_deframer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cfd_rx_if.sink                       rx_i,
  cfd_res_if.source                    res_o,
  input  logic                         cfg_we_i,
  input  logic [cfd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cfd_pkg::CfgDataW-1:0] cfg_wdata_i
);

  cfd_pkg::cfd_cfg_t    cfg;
  cfd_pkg::cfd_result_t res_d, res_q;
  logic                 out_valid_q;
  logic                 accept;

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  cfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_data_i (rx_i.rx_data),
    .cfg_i     (cfg),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.payload_valid = res_q.payload_valid;
  assign res_o.payload_byte  = res_q.payload_byte;
  assign res_o.lane          = res_q.lane;
  assign res_o.frame_end     = res_q.frame_end;
  assign res_o.verdict       = res_q.verdict;
  assign res_o.frame_length  = res_q.frame_length;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted byte produced no result beat");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> rx_i.ready)
    else $error("input stalled with empty result register");

  a_end_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.frame_end) |-> !res_q.payload_valid)
    else $error("payload byte flagged on frame end beat");

  a_verdict_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.frame_end) |-> (res_q.verdict == cfd_pkg::VerdictAccept))
    else $error("verdict given outside frame end");

  a_payload_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.payload_valid) |-> (res_q.frame_length != '0))
    else $error("payload byte in zero-length frame");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for command_frame_deframer_unit: drives received bytes,
// predicts each result beat from its own parser copy and compares it field by field.
// Depends on cfd_pkg and the cfd_rx_if / cfd_res_if interfaces.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [cfd_pkg::CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned LenCap = 48;

  typedef logic [7:0] byte_q_t [$];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         cfg_we_q    = 1'b0;
  logic [cfd_pkg::CfgIdxW-1:0]  cfg_index_q = '0;
  logic [cfd_pkg::CfgDataW-1:0] cfg_wdata_q = '0;
  logic                         rx_valid_q  = 1'b0;
  logic [7:0]                   rx_data_q   = '0;
  logic                         res_ready_q = 1'b0;

  cfd_rx_if  rx_ch ();
  cfd_res_if res_ch ();

  assign rx_ch.valid   = rx_valid_q;
  assign rx_ch.rx_data = rx_data_q;
  assign res_ch.ready  = res_ready_q;

  command_frame_deframer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we_q),
    .cfg_index_i (cfg_index_q),
    .cfg_wdata_i (cfg_wdata_q)
  );

  // parser copy
  cfd_pkg::cfd_cfg_t    cfg_shadow;
  cfd_pkg::cfd_phase_e  parse_ph = cfd_pkg::PhSync0;
  logic [15:0]          decl_len = '0;
  logic [15:0]          seen_cnt = '0;
  logic [15:0]          run_sum  = '0;
  logic [7:0]           ck_low   = '0;
  cfd_pkg::cfd_kind_e   cmd_kind = cfd_pkg::KindText;
  logic                 len_over = 1'b0;

  logic [7:0]           rx_bytes_todo [$];
  cfd_pkg::cfd_result_t results_due [$];
  cfd_pkg::cfd_result_t due_now;

  int  bytes_taken   = 0;
  int  results_seen  = 0;
  int  mismatches    = 0;
  int  settings_used = 0;
  int  frame_ends [5] = '{default: 0};
  int  tx_gap   = 0;
  int  rx_gap   = 0;
  bit  sender_idle_on = 1'b1;
  bit  sink_idle_on   = 1'b1;
  bit  hold_res       = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic cfd_pkg::cfd_result_t deframe_byte(input logic [7:0] b);
    cfd_pkg::cfd_result_t r;
    cfd_pkg::cfd_phase_e  cur;
    logic [15:0] ck;
    logic        framed;
    r = '0;
    cur = parse_ph;
    case (cur)
      cfd_pkg::PhSync0: begin
        if (b == cfg_shadow.sync_first) begin
          run_sum = {8'h00, b};
          parse_ph = cfd_pkg::PhSync1;
        end
      end
      cfd_pkg::PhSync1: begin
        if (b == cfg_shadow.sync_second) begin
          run_sum = run_sum + b;
          parse_ph = cfd_pkg::PhLen0;
        end else if (b == cfg_shadow.sync_first) begin
          run_sum = {8'h00, b};
        end else begin
          parse_ph = cfd_pkg::PhSync0;
        end
      end
      cfd_pkg::PhLen0: begin
        run_sum = run_sum + b;
        decl_len = {8'h00, b};
        parse_ph = cfd_pkg::PhLen1;
      end
      cfd_pkg::PhLen1: begin
        run_sum = run_sum + b;
        decl_len[15:8] = b;
        seen_cnt = '0;
        len_over = decl_len > cfg_shadow.max_payload;
        parse_ph = cfd_pkg::PhCmd;
      end
      cfd_pkg::PhCmd: begin
        run_sum = run_sum + b;
        if (b == cfg_shadow.text_command) cmd_kind = cfd_pkg::KindText;
        else if (b == cfg_shadow.binary_command) cmd_kind = cfd_pkg::KindBinary;
        else if (b == cfg_shadow.sdfs_command) cmd_kind = cfd_pkg::KindSdfs;
        else cmd_kind = cfd_pkg::KindUnrouted;
        parse_ph = (decl_len != 16'd0) ? cfd_pkg::PhPayload : cfd_pkg::PhCk0;
      end
      cfd_pkg::PhPayload: begin
        run_sum = run_sum + b;
        if (cmd_kind != cfd_pkg::KindUnrouted && !len_over) begin
          r.payload_valid = 1'b1;
          r.payload_byte = b;
        end
        seen_cnt = seen_cnt + 16'd1;
        if (seen_cnt >= decl_len) parse_ph = cfd_pkg::PhCk0;
      end
      cfd_pkg::PhCk0: begin
        ck_low = b;
        parse_ph = cfd_pkg::PhCk1;
      end
      default: begin
        ck = {b, ck_low};
        r.frame_end = 1'b1;
        if (ck != run_sum) r.verdict = cfd_pkg::VerdictChecksum;
        else if (len_over) r.verdict = cfd_pkg::VerdictOverlong;
        else if (cmd_kind == cfd_pkg::KindUnrouted) r.verdict = cfd_pkg::VerdictUnrouted;
        else if (cmd_kind == cfd_pkg::KindSdfs &&
                 (decl_len == 16'd0 || decl_len > cfg_shadow.sdfs_max_length))
          r.verdict = cfd_pkg::VerdictSdfsLen;
        else r.verdict = cfd_pkg::VerdictAccept;
        parse_ph = cfd_pkg::PhSync0;
      end
    endcase
    framed = (cur == cfd_pkg::PhCmd) || (cur == cfd_pkg::PhPayload) ||
             (cur == cfd_pkg::PhCk0) || (cur == cfd_pkg::PhCk1);
    if (framed && cmd_kind != cfd_pkg::KindUnrouted) r.lane = cmd_kind;
    if (framed || cur == cfd_pkg::PhLen1) r.frame_length = decl_len;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // byte driver: idle bursts of random length
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_q <= 1'b0;
      rx_data_q <= '0;
      tx_gap = 0;
    end else begin
      if (rx_valid_q && rx_ch.ready) begin
        results_due.push_back(deframe_byte(rx_data_q));
        bytes_taken++;
      end
      if (rx_valid_q && !rx_ch.ready) begin
      end else if (tx_gap > 0) begin
        tx_gap--;
        rx_valid_q <= 1'b0;
      end else if (rx_bytes_todo.size() != 0 && sender_idle_on &&
                   $urandom_range(0, 5) == 0) begin
        tx_gap = $urandom_range(0, 3);
        rx_valid_q <= 1'b0;
      end else if (rx_bytes_todo.size() != 0) begin
        rx_valid_q <= 1'b1;
        rx_data_q <= rx_bytes_todo.pop_front();
      end else begin
        rx_valid_q <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready_q <= 1'b0;
      rx_gap = 0;
    end else begin
      if (res_ch.valid && res_ready_q) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $error("result beat with no byte outstanding");
          mismatches++;
        end else begin
          due_now = results_due.pop_front();
          check_field("payload_valid", due_now.payload_valid, res_ch.payload_valid);
          check_field("payload_byte", due_now.payload_byte, res_ch.payload_byte);
          check_field("lane", due_now.lane, res_ch.lane);
          check_field("frame_end", due_now.frame_end, res_ch.frame_end);
          check_field("verdict", due_now.verdict, res_ch.verdict);
          check_field("frame_length", due_now.frame_length, res_ch.frame_length);
        end
        if (res_ch.frame_end && res_ch.verdict <= cfd_pkg::VerdictSdfsLen)
          frame_ends[res_ch.verdict]++;
      end
      if (hold_res) begin
        res_ready_q <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        res_ready_q <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(0, 3);
        res_ready_q <= 1'b0;
      end else begin
        res_ready_q <= 1'b1;
      end
    end
  end

  // long receiver stall so the result register fills and rx backs up
  initial begin
    wait (bytes_taken >= 600);
    @(negedge clk_i);
    hold_res = 1'b1;
    repeat (300) @(negedge clk_i);
    hold_res = 1'b0;
  end

  initial begin
    #30ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_reg(input logic [cfd_pkg::CfgIdxW-1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_q <= 1'b1;
    cfg_index_q <= idx;
    cfg_wdata_q <= value;
    case (idx)
      cfd_pkg::RegSyncFirst:     cfg_shadow.sync_first = value[7:0];
      cfd_pkg::RegSyncSecond:    cfg_shadow.sync_second = value[7:0];
      cfd_pkg::RegTextCommand:   cfg_shadow.text_command = value[7:0];
      cfd_pkg::RegBinaryCommand: cfg_shadow.binary_command = value[7:0];
      cfd_pkg::RegSdfsCommand:   cfg_shadow.sdfs_command = value[7:0];
      cfd_pkg::RegMaxPayload:    cfg_shadow.max_payload = value;
      cfd_pkg::RegSdfsMaxLength: cfg_shadow.sdfs_max_length = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_q <= 1'b0;
  endtask

  // upper wdata bits of the 8-bit registers carry junk on purpose
  task automatic set_config(input logic [7:0] sf, input logic [7:0] ss, input logic [7:0] tc,
                            input logic [7:0] bc, input logic [7:0] sc,
                            input logic [15:0] mp, input logic [15:0] sm);
    write_reg(cfd_pkg::RegSyncFirst, {8'($urandom), sf});
    write_reg(cfd_pkg::RegSyncSecond, {8'($urandom), ss});
    write_reg(cfd_pkg::RegTextCommand, {8'($urandom), tc});
    write_reg(cfd_pkg::RegBinaryCommand, {8'($urandom), bc});
    write_reg(cfd_pkg::RegSdfsCommand, {8'($urandom), sc});
    write_reg(cfd_pkg::RegMaxPayload, mp);
    write_reg(cfd_pkg::RegSdfsMaxLength, sm);
    write_reg(RegUnused, 16'($urandom));
    settings_used++;
  endtask

  task automatic wait_drained();
    while (rx_bytes_todo.size() != 0 || rx_valid_q || results_due.size() != 0)
      @(negedge clk_i);
  endtask

  function automatic byte_q_t build_frame(input logic [7:0] cmd, input logic [15:0] len,
                                          input bit corrupt, input bit rep_sync,
                                          input bit extreme_fill);
    byte_q_t     f;
    logic [15:0] sum;
    logic [7:0]  pb;
    f = {};
    if (rep_sync) f.push_back(cfg_shadow.sync_first);
    f.push_back(cfg_shadow.sync_first);
    f.push_back(cfg_shadow.sync_second);
    f.push_back(len[7:0]);
    f.push_back(len[15:8]);
    f.push_back(cmd);
    sum = cfg_shadow.sync_first + cfg_shadow.sync_second + len[7:0] + len[15:8] + cmd;
    for (int i = 0; i < len; i++) begin
      pb = extreme_fill ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom);
      f.push_back(pb);
      sum = sum + pb;
    end
    if (corrupt) sum = sum ^ 16'($urandom_range(1, 65535));
    f.push_back(sum[7:0]);
    f.push_back(sum[15:8]);
    return f;
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 3))
      0: return cfg_shadow.text_command;
      1: return cfg_shadow.binary_command;
      2: return cfg_shadow.sdfs_command;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_length();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'd0;
    if (sel == 1 && cfg_shadow.max_payload <= LenCap) return cfg_shadow.max_payload;
    if (sel == 2 && cfg_shadow.max_payload < LenCap) return cfg_shadow.max_payload + 16'd1;
    if (sel == 3 && cfg_shadow.sdfs_max_length <= LenCap) return cfg_shadow.sdfs_max_length;
    if (sel == 4 && cfg_shadow.sdfs_max_length < LenCap)
      return cfg_shadow.sdfs_max_length + 16'd1;
    return 16'($urandom_range(1, 12));
  endfunction

  // mostly well-formed frames, some noise, stray syncs and cut-off frames
  task automatic fill_random(input int n);
    int         pushed;
    int         sel;
    byte_q_t    f;
    logic [7:0] junk;
    bit         rep;
    pushed = 0;
    while (pushed < n) begin
      sel = $urandom_range(0, 11);
      if (sel == 0) begin
        f = {};
        repeat ($urandom_range(1, 4)) f.push_back(8'($urandom));
      end else if (sel == 1) begin
        junk = 8'($urandom);
        while (junk == cfg_shadow.sync_first || junk == cfg_shadow.sync_second)
          junk = junk + 8'd1;
        f = {cfg_shadow.sync_first, junk};
      end else begin
        rep = cfg_shadow.sync_first != cfg_shadow.sync_second && $urandom_range(0, 5) == 0;
        f = build_frame(pick_command(), pick_length(), $urandom_range(0, 7) == 0, rep, 1'b0);
        if (sel == 2) f = f[0:$urandom_range(5, f.size() - 2)];
      end
      rx_bytes_todo = {rx_bytes_todo, f};
      pushed += f.size();
    end
  endtask

  initial begin
    byte_q_t     f;
    logic [7:0]  sf, ss, tc, bc, sc;
    logic [15:0] mp, sm;
    cfg_shadow = '{cfd_pkg::SyncFirstRst, cfd_pkg::SyncSecondRst, cfd_pkg::TextCommandRst,
                   cfd_pkg::BinaryCommandRst, cfd_pkg::SdfsCommandRst,
                   cfd_pkg::MaxPayloadRst, cfd_pkg::SdfsMaxLengthRst};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed frames under reset settings
    rx_bytes_todo = {rx_bytes_todo,
                     build_frame(cfd_pkg::TextCommandRst, 16'd0, 1'b0, 1'b1, 1'b0)};
    rx_bytes_todo = {rx_bytes_todo,
                     build_frame(cfd_pkg::BinaryCommandRst, 16'd2, 1'b0, 1'b0, 1'b1)};
    rx_bytes_todo = {rx_bytes_todo, build_frame(8'h00, 16'd0, 1'b0, 1'b0, 1'b0)};
    rx_bytes_todo = {rx_bytes_todo,
                     build_frame(cfd_pkg::SdfsCommandRst, 16'd0, 1'b0, 1'b0, 1'b0)};
    rx_bytes_todo = {rx_bytes_todo,
                     build_frame(cfd_pkg::SdfsCommandRst, 16'd1, 1'b1, 1'b0, 1'b0)};
    rx_bytes_todo.push_back(cfd_pkg::SyncFirstRst);
    rx_bytes_todo.push_back(8'h00);
    // limits change after the length is in but before the command byte
    f = build_frame(cfd_pkg::SdfsCommandRst, 16'd3, 1'b0, 1'b0, 1'b0);
    rx_bytes_todo = {rx_bytes_todo, f[0:3]};
    wait_drained();
    write_reg(cfd_pkg::RegMaxPayload, 16'd0);
    write_reg(cfd_pkg::RegSdfsMaxLength, 16'd1);
    @(negedge clk_i);
    rx_bytes_todo = {rx_bytes_todo, f[4:$]};

    // extreme settings, colliding command codes
    wait_drained();
    set_config(8'hFF, 8'h00, 8'h00, 8'h80, 8'h80, 16'd0, 16'd1);
    @(negedge clk_i);
    fill_random(150);

    repeat (5) begin
      wait_drained();
      sender_idle_on = $urandom_range(0, 3) != 0;
      sink_idle_on = $urandom_range(0, 3) != 0;
      sf = 8'($urandom);
      ss = ($urandom_range(0, 7) == 0) ? sf : 8'($urandom);
      tc = 8'($urandom);
      bc = ($urandom_range(0, 3) == 0) ? tc : 8'($urandom);
      sc = ($urandom_range(0, 3) == 0) ? bc : 8'($urandom);
      case ($urandom_range(0, 3))
        0: mp = 16'd512;
        1: mp = 16'hFFFF;
        default: mp = 16'($urandom_range(0, 40));
      endcase
      sm = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(1, 40));
      set_config(sf, ss, tc, bc, sc, mp, sm);
      @(negedge clk_i);
      fill_random(150);
    end

    // one long frame with a nonzero high length byte, past the sdfs limit
    wait_drained();
    sender_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    set_config(cfd_pkg::SyncFirstRst, cfd_pkg::SyncSecondRst, 8'h5A, 8'h5A, 8'hA5,
               16'hFFFF, 16'h0100);
    @(negedge clk_i);
    rx_bytes_todo = {rx_bytes_todo, build_frame(8'hA5, 16'h0101, 1'b0, 1'b0, 1'b0)};

    // back to reset values, no idling
    wait_drained();
    sender_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    set_config(cfd_pkg::SyncFirstRst, cfd_pkg::SyncSecondRst, cfd_pkg::TextCommandRst,
               cfd_pkg::BinaryCommandRst, cfd_pkg::SdfsCommandRst,
               cfd_pkg::MaxPayloadRst, cfd_pkg::SdfsMaxLengthRst);
    @(negedge clk_i);
    fill_random(150);

    wait_drained();
    repeat (4) @(negedge clk_i);
    $display("Sent %0d bytes under %0d register settings, %0d result beats compared.",
             bytes_taken, settings_used, results_seen);
    $display("Frame ends: %0d accepted, %0d bad checksum, %0d overlong, %0d unrouted, %0d sdfs",
             frame_ends[0], frame_ends[1], frame_ends[2], frame_ends[3], frame_ends[4]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
